@@ hw/rtl/crc16f_pkg.sv @@
// ----------------------------------------------------------------------------
// crc16f_pkg
// Shared widths, types and CRC-16/MODBUS constants for the frame builder.
// ----------------------------------------------------------------------------
package crc16f_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned NUM_CH    = 4;
  localparam int unsigned DATA_W    = SAMPLE_W * NUM_CH;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CRC_W     = 16;
  localparam int unsigned FRAME_LEN = 10;
  localparam int unsigned FRAME_W   = FRAME_LEN * BYTE_W;
  localparam int unsigned CNT_W     = 4;

  typedef logic [DATA_W-1:0]             data_t;
  typedef logic [CRC_W-1:0]              crc_t;
  typedef logic [FRAME_W-1:0]            frame_t;
  typedef logic [BYTE_W-1:0]             byte_t;
  typedef logic [CNT_W-1:0]              cnt_t;
  typedef logic [DATA_W-1:0][CRC_W-1:0]  crc_mask_t;

  localparam crc_t CRC_INIT = 16'hFFFF;
  localparam crc_t CRC_POLY = 16'hA001;
  localparam cnt_t LAST_IDX = CNT_W'(FRAME_LEN - 1);

  // Bit-serial reflected CRC, data taken from bit 0 upwards.
  // Only evaluated with constant arguments to build the tables below.
  function automatic crc_t crc_serial(crc_t init, data_t data);
    crc_t c;
    logic fb;
    int   i;
    c = init;
    for (i = 0; i < int'(DATA_W); i++) begin
      fb = c[0] ^ data[i];
      c  = {1'b0, c[CRC_W-1:1]};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // Contribution of each data bit on its own, with a zero start value.
  function automatic crc_mask_t crc_masks();
    crc_mask_t m;
    int        i;
    for (i = 0; i < int'(DATA_W); i++) begin
      m[i] = crc_serial('0, data_t'(1) << i);
    end
    return m;
  endfunction

  // The CRC is linear: result = CRC of all-zero data ^ masks of set bits.
  localparam crc_t      CRC_ZERO  = crc_serial(CRC_INIT, '0);
  localparam crc_mask_t CRC_MASKS = crc_masks();

endpackage

@@ hw/rtl/crc16f_crc.sv @@
// ----------------------------------------------------------------------------
// crc16f_crc
// Single-pass CRC-16/MODBUS over the eight sample bytes as an XOR tree.
// ----------------------------------------------------------------------------
module crc16f_crc (
  input  crc16f_pkg::data_t data,
  output crc16f_pkg::crc_t  crc
);

  always_comb begin
    crc16f_pkg::crc_t acc;
    acc = crc16f_pkg::CRC_ZERO;
    for (int i = 0; i < int'(crc16f_pkg::DATA_W); i++) begin
      if (data[i]) begin
        acc = acc ^ crc16f_pkg::CRC_MASKS[i];
      end
    end
    crc = acc;
  end

endmodule

@@ hw/rtl/crc16f_ser.sv @@
// ----------------------------------------------------------------------------
// crc16f_ser
// Frame register that shifts out one byte per accepted output word.
// ----------------------------------------------------------------------------
module crc16f_ser (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  crc16f_pkg::frame_t  frame,
  output logic                free,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output crc16f_pkg::byte_t   m_axis_tdata,
  output logic                m_axis_tlast
);

  logic                busy;
  crc16f_pkg::cnt_t    cnt;
  crc16f_pkg::frame_t  shreg;
  logic                take;
  logic                last;

  assign take = m_axis_tvalid && m_axis_tready;
  assign last = (cnt == crc16f_pkg::LAST_IDX);
  assign free = !busy || (take && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (take) begin
      cnt <= cnt + 1'b1;
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shreg <= frame;
    end else if (take) begin
      shreg <= shreg >> crc16f_pkg::BYTE_W;
    end
  end

  assign m_axis_tvalid = busy;
  assign m_axis_tdata  = shreg[crc16f_pkg::BYTE_W-1:0];
  assign m_axis_tlast  = last;

endmodule

@@ hw/rtl/four_channel_crc16_frame_builder.sv @@
// ----------------------------------------------------------------------------
// four_channel_crc16_frame_builder
// Packs four 16-bit samples into a 10-byte frame closed by CRC-16/MODBUS.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one word of four samples, channel 0 in the lowest bits.
//   m_axis returns ten byte words per input word: each sample low byte then
//   high byte in channel order, then the CRC low byte and high byte; tlast
//   marks the tenth byte.
//   Path: an accepted input word is held in the input register, then loaded
//   into the frame register once that register is free; its first byte is
//   valid on the output from then on.
//   The single byte output port sets the rate of input words; the input
//   register accepts the next word while the current frame is still
//   draining.
//   Reset (synchronous, active high) empties both registers; the output
//   shows no valid word in the cycle after reset.
//   When the receiver stalls, the current byte holds and the input register
//   fills up once, after which s_axis_tready drops.
// ----------------------------------------------------------------------------
module four_channel_crc16_frame_builder (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [15:0] sample_ch0, [31:16] sample_ch1, [47:32] sample_ch2, [63:48] sample_ch3
  input  crc16f_pkg::data_t   s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] frame_byte
  output crc16f_pkg::byte_t   m_axis_tdata,
  output logic                m_axis_tlast
);

  logic                in_full;
  crc16f_pkg::data_t   samples;
  crc16f_pkg::crc_t    crc;
  logic                ser_free;
  logic                ser_load;

  assign ser_load      = in_full && ser_free;
  assign s_axis_tready = !in_full || ser_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_full <= 1'b1;
    end else if (ser_load) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      samples <= s_axis_tdata;
    end
  end

  crc16f_crc u_crc (
    .data (samples),
    .crc  (crc)
  );

  crc16f_ser u_ser (
    .clk           (clk),
    .rst           (rst),
    .load          (ser_load),
    .frame         ({crc, samples}),
    .free          (ser_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ hw/rtl/crc16f_chk.sv @@
// ----------------------------------------------------------------------------
// crc16f_chk
// Port-level checks for the frame builder, bound to the top level.
// ----------------------------------------------------------------------------
module crc16f_chk (
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input crc16f_pkg::byte_t  m_axis_tdata,
  input logic               m_axis_tlast
);

  crc16f_pkg::cnt_t  byte_cnt;
  logic [2:0]        pend;
  logic              in_take;
  logic              out_take;
  logic              frame_done;

  assign in_take    = s_axis_tvalid && s_axis_tready;
  assign out_take   = m_axis_tvalid && m_axis_tready;
  assign frame_done = out_take && m_axis_tlast;

  // Count bytes within the frame and frames held inside the block.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_cnt <= '0;
      pend     <= '0;
    end else begin
      if (out_take) begin
        byte_cnt <= m_axis_tlast ? '0 : byte_cnt + 1'b1;
      end
      pend <= pend + {2'b00, in_take} - {2'b00, frame_done};
    end
  end

  a_tlast_pos: assert property (@(posedge clk) disable iff (rst)
    out_take |-> (m_axis_tlast == (byte_cnt == crc16f_pkg::LAST_IDX)))
    else $error("tlast not on the tenth byte of a frame");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (pend != 3'd0))
    else $error("output word with no input word outstanding");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    pend <= 3'd2)
    else $error("more than two frames held");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind four_channel_crc16_frame_builder crc16f_chk u_crc16f_chk (.*);
